// ===== hdl/udcnt_pkg.sv =====
// ----------------------------------------------------------------------------
// udcnt_pkg
// Shared types and constants for the up/down counter with seven-segment scan.
// ----------------------------------------------------------------------------
package udcnt_pkg;

  localparam int CountWidth = 14;
  localparam int TickWidth  = 8;

  // Debouncer phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_DWELL    = 1'b1;

  localparam logic [CountWidth-1:0] COUNT_MAX = 14'd9999;

  // Reset values of the configuration registers.
  localparam logic [TickWidth-1:0] DEBOUNCE_RESET = 8'd2;
  localparam logic [TickWidth-1:0] DWELL_RESET    = 8'd5;

  // Common-anode segment codes for the decimal digits, point off.
  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic up_line;
    logic down_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            segments;
    logic [3:0]            digit_select;
    logic [CountWidth-1:0] count_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [TickWidth-1:0] timer;
  } btn_state_t;

  typedef struct packed {
    btn_state_t state;
    logic       fire;
  } btn_step_t;

endpackage

// ===== hdl/updown_counter_seven_segment_scan_unit.sv =====
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan_unit
// Four-digit decimal up/down counter with two debounced buttons and a
// multiplexed common-anode seven-segment display driver.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -------------------------------
//  in        input      in_valid / in_ready    in_data  (up_line, down_line)
//  out       output     out_valid / out_ready  out_data (segments, digit_select,
//                                                        count_value)
//  cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// Each request is one millisecond tick: the debouncers, the counter and the
// scan update at the accepting edge, where the result is loaded into the
// output register. A new request is taken whenever that register is empty or
// is being emptied, so one tick per clock is sustained while out_ready holds.
// Reset (synchronous, active high) clears the count, debouncers and scan and
// restores debounce 2 and dwell 5. A stalled output holds and drops in_ready.
// ----------------------------------------------------------------------------
module updown_counter_seven_segment_scan_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  udcnt_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output udcnt_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data
);

  import udcnt_pkg::*;

  // Configuration registers.
  logic [TickWidth-1:0] debounce_ticks;
  logic [TickWidth-1:0] dwell_ticks;

  // Tick state. The count is kept both in binary, for the count output, and
  // as four BCD digits (index 0 is thousands), so the display needs no
  // division. Both copies step together and always agree.
  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic [3:0]            bcd      [4];
  logic [3:0]            bcd_next [4];
  btn_state_t            up_btn;
  btn_state_t            down_btn;
  btn_step_t             up_step;
  btn_step_t             down_step;
  logic [1:0]            scan_digit;
  logic [1:0]            scan_digit_next;
  logic [TickWidth-1:0]  dwell_timer;
  logic [TickWidth-1:0]  dwell_timer_next;

  logic [TickWidth-1:0]  debounce_limit;
  logic [TickWidth-1:0]  dwell_limit;
  logic                  in_accept;
  logic                  do_up;
  logic                  do_down;
  logic                  carry;
  out_item_t             result;

  // A zero setting in either register behaves as one.
  assign debounce_limit = (debounce_ticks == '0) ? TickWidth'(1) : debounce_ticks;
  assign dwell_limit    = (dwell_ticks == '0) ? TickWidth'(1) : dwell_ticks;

  // The output register is the only stage; it frees itself when it is taken.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // One debouncer step. A press is confirmed by a second low sample
  // debounce_ticks after the first one and counts when the line goes high.
  function automatic btn_step_t btn_advance(btn_state_t cur, logic line,
                                            logic [TickWidth-1:0] limit);
    btn_step_t r;
    r.state = cur;
    r.fire  = 1'b0;
    case (cur.phase)
      PH_WAIT: begin
        r.state.timer = cur.timer + TickWidth'(1);
        if (r.state.timer >= limit) begin
          r.state.phase = line ? PH_IDLE : PH_HELD;
          r.state.timer = '0;
        end
      end
      PH_HELD: begin
        if (line) begin
          r.state.phase = PH_IDLE;
          r.fire        = 1'b1;
        end
      end
      default: begin
        r.state.phase = PH_IDLE;
        if (!line) begin
          r.state.phase = PH_WAIT;
          r.state.timer = '0;
        end
      end
    endcase
    return r;
  endfunction

  assign up_step   = btn_advance(up_btn, in_data.up_line, debounce_limit);
  assign down_step = btn_advance(down_btn, in_data.down_line, debounce_limit);

  // Simultaneous presses cancel each other.
  assign do_up   = up_step.fire && !down_step.fire;
  assign do_down = down_step.fire && !up_step.fire;

  // Counter update, binary and BCD, with wrap at both ends.
  always_comb begin
    count_next = count;
    bcd_next   = bcd;
    carry      = 1'b1;
    if (do_up) begin
      if (count >= COUNT_MAX) begin
        count_next = '0;
        for (int i = 0; i < 4; i++) begin
          bcd_next[i] = 4'd0;
        end
      end else begin
        count_next = count + CountWidth'(1);
        for (int i = 3; i >= 0; i--) begin
          if (carry) begin
            if (bcd[i] >= 4'd9) begin
              bcd_next[i] = 4'd0;
            end else begin
              bcd_next[i] = bcd[i] + 4'd1;
              carry       = 1'b0;
            end
          end
        end
      end
    end else if (do_down) begin
      if (count == '0) begin
        count_next = COUNT_MAX;
        for (int i = 0; i < 4; i++) begin
          bcd_next[i] = 4'd9;
        end
      end else begin
        count_next = count - CountWidth'(1);
        for (int i = 3; i >= 0; i--) begin
          if (carry) begin
            if (bcd[i] == 4'd0) begin
              bcd_next[i] = 4'd9;
            end else begin
              bcd_next[i] = bcd[i] - 4'd1;
              carry       = 1'b0;
            end
          end
        end
      end
    end
  end

  // The shown digit comes from the updated count and the current scan
  // position; digit select is one-cold, bit 0 for the thousands digit.
  always_comb begin
    result.count_value  = count_next;
    result.digit_select = ~(4'b0001 << scan_digit);
    if (bcd_next[scan_digit] > 4'd9) begin
      result.segments = SEG_CODE[9];
    end else begin
      result.segments = SEG_CODE[bcd_next[scan_digit]];
    end
  end

  // The scan moves on after the output has been formed.
  always_comb begin
    dwell_timer_next = dwell_timer + TickWidth'(1);
    scan_digit_next  = scan_digit;
    if (dwell_timer_next >= dwell_limit) begin
      dwell_timer_next = '0;
      scan_digit_next  = scan_digit + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      dwell_ticks    <= DWELL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks <= cfg_data;
        REG_DWELL:    dwell_ticks    <= cfg_data;
        default:      debounce_ticks <= debounce_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      up_btn      <= '{phase: PH_IDLE, timer: '0};
      down_btn    <= '{phase: PH_IDLE, timer: '0};
      scan_digit  <= '0;
      dwell_timer <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        bcd[i] <= 4'd0;
      end
    end else begin
      if (in_accept) begin
        count       <= count_next;
        bcd         <= bcd_next;
        up_btn      <= up_step.state;
        down_btn    <= down_step.state;
        scan_digit  <= scan_digit_next;
        dwell_timer <= dwell_timer_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // Exactly one digit is enabled in every result.
  a_one_cold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~out_data.digit_select))
    else $error("digit select is not one-cold");

  // The counter never leaves the decimal range.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.count_value <= COUNT_MAX))
    else $error("count out of range");

  // The BCD copy tracks the binary count.
  a_bcd_match: assert property (@(posedge clk) disable iff (rst)
    count == (CountWidth'(bcd[0]) * CountWidth'(1000)
            + CountWidth'(bcd[1]) * CountWidth'(100)
            + CountWidth'(bcd[2]) * CountWidth'(10)
            + CountWidth'(bcd[3])))
    else $error("BCD digits disagree with binary count");

  // An accepted tick always leaves a result in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted tick produced no result");
`endif

endmodule
